@@ rtl/core/phmc_pkg.sv @@
// Shared types, widths and arithmetic helpers of the pixel hue material classifier.
package phmc_pkg;

  localparam int ColorW  = 8;
  localparam int ChromaW = 10;   // 2a-b-c of 8-bit values: -510..510
  localparam int NormW   = 19;   // squared chroma, at most 390150
  localparam int DotW    = 20;   // signed dot product of two chroma vectors
  localparam int ProdW   = 38;   // dot^2 and product of squared norms
  localparam int RemW    = 68;   // dot^2 scaled by 2^30
  localparam int AccW    = 53;   // partial root times denominator
  localparam int RootW   = 15;   // root bits resolved by the cell chain
  localparam int CandW   = 69;
  localparam int CosW    = 16;
  localparam int NfSqW   = 20;   // 9 * noise_floor^2
  localparam int IdW     = 8;
  localparam int CntW    = 3;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int NumWords = 4;

  localparam logic signed [CosW-1:0] CosThrReset = 16'sd28378;
  localparam logic [ColorW-1:0]      NoiseReset  = 8'd14;
  localparam logic [CosW-1:0]        CosMaxPos   = 16'h7fff;
  localparam logic [CosW-1:0]        CosMaxNeg   = 16'h8000;

  typedef enum logic [2:0] {
    REG_COS_THR     = 3'd0,
    REG_NOISE_LVL   = 3'd1,
    REG_REF_COUNT   = 3'd2,
    REG_REF_WORD0   = 3'd3,
    REG_REF_WORD1   = 3'd4,
    REG_REF_WORD2   = 3'd5,
    REG_REF_WORD3   = 3'd6
  } reg_idx_e;

  typedef logic signed [ChromaW-1:0] chroma_t;

  // One reference lane of the integer square-root search.
  typedef struct packed {
    logic [ProdW-1:0] den;
    logic [RemW-1:0]  rem;
    logic [AccW-1:0]  acc;
    logic [RootW-1:0] root;
    logic             neg;
    logic             zero;
    logic             sat;
  } lane_t;

  typedef struct packed {
    logic opaque;
    logic quiet;
  } meta_t;

  function automatic chroma_t chroma_axis(logic [ColorW-1:0] a, logic [ColorW-1:0] b,
                                          logic [ColorW-1:0] c);
    logic signed [ChromaW:0] s;
    s = $signed({2'b00, a, 1'b0}) - $signed({3'b000, b}) - $signed({3'b000, c});
    return s[ChromaW-1:0];
  endfunction

  function automatic logic [NormW-1:0] norm3(chroma_t a, chroma_t b, chroma_t c);
    logic signed [2*ChromaW:0] s;
    s = a * a + b * b + c * c;
    return s[NormW-1:0];
  endfunction

  function automatic logic signed [DotW-1:0] dot3(chroma_t a0, chroma_t a1, chroma_t a2,
                                                   chroma_t b0, chroma_t b1, chroma_t b2);
    logic signed [2*ChromaW:0] s;
    s = a0 * b0 + a1 * b1 + a2 * b2;
    return s[DotW-1:0];
  endfunction

endpackage

@@ rtl/core/phmc_stream_if.sv @@
// Valid/ready stream interfaces for pixels in and material results out.
interface phmc_pix_if;
  import phmc_pkg::*;
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] pixel_red;
  logic [ColorW-1:0] pixel_green;
  logic [ColorW-1:0] pixel_blue;
  logic [ColorW-1:0] pixel_alpha;
  modport source (output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                  input ready);
  modport sink (input valid, pixel_red, pixel_green, pixel_blue, pixel_alpha,
                output ready);
endinterface

interface phmc_res_if;
  import phmc_pkg::*;
  logic           valid;
  logic           ready;
  logic [IdW-1:0] mat_id;
  logic           matched;
  modport source (output valid, mat_id, matched, input ready);
  modport sink (input valid, mat_id, matched, output ready);
endinterface

@@ rtl/core/phmc_cell.sv @@
// One square-root cell: resolves a single root bit for every reference lane.
module phmc_cell #(
  parameter int MAX_REFS = 4,
  parameter int BIT      = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  phmc_pkg::meta_t  meta_i,
  input  phmc_pkg::lane_t  lane_i [MAX_REFS],
  output logic             valid_o,
  input  logic             ready_i,
  output phmc_pkg::meta_t  meta_o,
  output phmc_pkg::lane_t  lane_o [MAX_REFS]
);
  import phmc_pkg::*;

  logic  valid_q;
  meta_t meta_q;
  lane_t lane_q [MAX_REFS];
  lane_t lane_d [MAX_REFS];

  // Try root bit: (2R+b)*b*den = 2b*(R*den) + b^2*den, no multiplier needed.
  always_comb begin
    logic [CandW-1:0] acc_x;
    logic [CandW-1:0] den_x;
    logic [CandW-1:0] cand;
    for (int k = 0; k < MAX_REFS; k++) begin
      lane_d[k] = lane_i[k];
      acc_x = CandW'(lane_i[k].acc) << (BIT + 1);
      den_x = CandW'(lane_i[k].den) << (2 * BIT);
      cand  = acc_x + den_x;
      if (cand <= CandW'(lane_i[k].rem)) begin
        lane_d[k].rem  = lane_i[k].rem - cand[RemW-1:0];
        lane_d[k].acc  = lane_i[k].acc + (AccW'(lane_i[k].den) << BIT);
        lane_d[k].root = lane_i[k].root | (RootW'(1) << BIT);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      meta_q <= meta_i;
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign lane_o  = lane_q;

endmodule

@@ rtl/core/pixel_hue_material_classifier.sv @@
// Top level: APB register file, chroma and product stages, root cell chain, winner select.
// Takes one pixel per clock while no stalled result holds the pipeline and returns its
// material id; most of its depth is the chain of 15 root cells, one cell per bit of the
// Q1.15 cosine, which all reference lanes pass through side by side. Three stages
// ahead of the chain form chroma, norms, dot products and their products; the
// stage after it picks the winner and holds the result. A stalled result
// stops only the stages behind it that are full.
module pixel_hue_material_classifier #(
  parameter int MAX_REFS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  phmc_pix_if.sink                     pix_i,
  phmc_res_if.source                   res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [phmc_pkg::AddrW-1:0]   paddr,
  input  logic [phmc_pkg::DataW-1:0]   pwdata,
  output logic [phmc_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import phmc_pkg::*;

  // Configuration
  logic signed [CosW-1:0] thr_q;
  logic [ColorW-1:0]      nf_q;
  logic [CntW-1:0]        cnt_q;
  logic [DataW-1:0]       word_q [NumWords];
  reg_idx_e               widx;
  logic                   wr_en;

  assign pready = 1'b1;
  assign widx   = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= CosThrReset;
      nf_q  <= NoiseReset;
      cnt_q <= '0;
      for (int k = 0; k < NumWords; k++) word_q[k] <= '0;
    end else if (wr_en) begin
      case (widx)
        REG_COS_THR:     thr_q     <= pwdata[CosW-1:0];
        REG_NOISE_LVL:   nf_q      <= pwdata[ColorW-1:0];
        REG_REF_COUNT:   cnt_q     <= pwdata[CntW-1:0];
        REG_REF_WORD0:   word_q[0] <= pwdata;
        REG_REF_WORD1:   word_q[1] <= pwdata;
        REG_REF_WORD2:   word_q[2] <= pwdata;
        REG_REF_WORD3:   word_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_COS_THR:     prdata = DataW'(thr_q[CosW-1:0]);
      REG_NOISE_LVL:   prdata = DataW'(nf_q);
      REG_REF_COUNT:   prdata = DataW'(cnt_q);
      REG_REF_WORD0:   prdata = word_q[0];
      REG_REF_WORD1:   prdata = word_q[1];
      REG_REF_WORD2:   prdata = word_q[2];
      REG_REF_WORD3:   prdata = word_q[3];
      default:         prdata = '0;
    endcase
  end

  // Reference chroma and values derived from configuration
  chroma_t          qv [MAX_REFS][3];
  logic [NormW-1:0] qn_q [MAX_REFS];
  logic [NfSqW-1:0] nf9_q;

  always_comb begin
    for (int k = 0; k < MAX_REFS; k++) begin
      qv[k][0] = chroma_axis(word_q[k][23:16], word_q[k][15:8], word_q[k][7:0]);
      qv[k][1] = chroma_axis(word_q[k][15:8], word_q[k][23:16], word_q[k][7:0]);
      qv[k][2] = chroma_axis(word_q[k][7:0], word_q[k][23:16], word_q[k][15:8]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_REFS; k++) qn_q[k] <= norm3(qv[k][0], qv[k][1], qv[k][2]);
    nf9_q <= NfSqW'(nf_q) * NfSqW'(nf_q) * NfSqW'(9);
  end

  // Ready chain
  logic rdy1, rdy2, rdy3, rdy_out;
  logic v1_q, v2_q, v3_q;
  logic chain_ready;

  assign rdy3  = !v3_q || chain_ready;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign pix_i.ready = rdy1;

  // Stage 1: pixel chroma
  chroma_t pv1_q [3];
  logic    op1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pix_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      pv1_q[0] <= chroma_axis(pix_i.pixel_red, pix_i.pixel_green, pix_i.pixel_blue);
      pv1_q[1] <= chroma_axis(pix_i.pixel_green, pix_i.pixel_red, pix_i.pixel_blue);
      pv1_q[2] <= chroma_axis(pix_i.pixel_blue, pix_i.pixel_red, pix_i.pixel_green);
      op1_q    <= pix_i.pixel_alpha != '0;
    end
  end

  // Stage 2: pixel norm and dot products
  logic [NormW-1:0]       pn2_q;
  logic signed [DotW-1:0] dot2_q [MAX_REFS];
  logic                   op2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      pn2_q <= norm3(pv1_q[0], pv1_q[1], pv1_q[2]);
      for (int k = 0; k < MAX_REFS; k++) begin
        dot2_q[k] <= dot3(pv1_q[0], pv1_q[1], pv1_q[2], qv[k][0], qv[k][1], qv[k][2]);
      end
      op2_q <= op1_q;
    end
  end

  // Stage 3: squared dot and norm product
  logic [ProdW-1:0] den3_q [MAX_REFS];
  logic [ProdW-1:0] d23_q  [MAX_REFS];
  logic             neg3_q [MAX_REFS];
  logic             zero3_q [MAX_REFS];
  meta_t            meta3_q;

  always_ff @(posedge clk_i) begin
    logic [DotW-1:0] mag;
    if (rdy3) begin
      for (int k = 0; k < MAX_REFS; k++) begin
        mag         = dot2_q[k][DotW-1] ? DotW'(-dot2_q[k]) : DotW'(dot2_q[k]);
        den3_q[k]  <= ProdW'(pn2_q) * ProdW'(qn_q[k]);
        d23_q[k]   <= ProdW'(mag) * ProdW'(mag);
        neg3_q[k]  <= dot2_q[k][DotW-1];
        zero3_q[k] <= (pn2_q == '0) || (qn_q[k] == '0);
      end
      meta3_q.opaque <= op2_q;
      meta3_q.quiet  <= NfSqW'(pn2_q) < nf9_q;
    end
  end

  // Root cell chain: cosine magnitude is the largest R with R^2*den <= dot^2*2^30
  lane_t lane_in [MAX_REFS];
  lane_t lanes   [RootW+1][MAX_REFS];
  meta_t metas   [RootW+1];
  logic  cvalid  [RootW+1];
  logic  cready  [RootW+1];

  always_comb begin
    for (int k = 0; k < MAX_REFS; k++) begin
      lane_in[k].den  = den3_q[k];
      lane_in[k].rem  = {d23_q[k], 30'b0};
      lane_in[k].acc  = '0;
      lane_in[k].root = '0;
      lane_in[k].neg  = neg3_q[k];
      lane_in[k].zero = zero3_q[k];
      lane_in[k].sat  = !zero3_q[k] && (den3_q[k] <= d23_q[k]);
    end
  end

  assign lanes[0]  = lane_in;
  assign metas[0]  = meta3_q;
  assign cvalid[0] = v3_q;
  assign chain_ready = cready[0];
  assign cready[RootW] = rdy_out;

  for (genvar j = 0; j < RootW; j++) begin : g_cell
    phmc_cell #(
      .MAX_REFS(MAX_REFS),
      .BIT     (RootW - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cvalid[j]),
      .ready_o(cready[j]),
      .meta_i (metas[j]),
      .lane_i (lanes[j]),
      .valid_o(cvalid[j+1]),
      .ready_i(cready[j+1]),
      .meta_o (metas[j+1]),
      .lane_o (lanes[j+1])
    );
  end

  // Winner select and result register
  logic                ov_q;
  logic [IdW-1:0]      id_q;
  logic                matched_q;
  logic [IdW-1:0]      id_d;
  logic                matched_d;
  logic [CntW-1:0]     n_use;

  assign rdy_out = !ov_q || res_o.ready;
  assign n_use   = (cnt_q > CntW'(MAX_REFS)) ? CntW'(MAX_REFS) : cnt_q;

  always_comb begin
    logic signed [CosW-1:0] cs;
    logic signed [CosW-1:0] best;
    lane_t l;
    id_d      = '0;
    matched_d = 1'b0;
    best      = '0;
    for (int k = 0; k < MAX_REFS; k++) begin
      l = lanes[RootW][k];
      if (l.zero) begin
        cs = '0;
      end else if (l.sat) begin
        cs = l.neg ? CosMaxNeg : CosMaxPos;
      end else if (l.neg) begin
        cs = -$signed(CosW'(l.root));
      end else begin
        cs = $signed(CosW'(l.root));
      end
      if (metas[RootW].opaque && (CntW'(k) < n_use) &&
          (metas[RootW].quiet || cs >= thr_q)) begin
        if (!matched_d || cs > best) begin
          best      = cs;
          matched_d = 1'b1;
          id_d      = word_q[k][31:24];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (rdy_out) begin
      ov_q <= cvalid[RootW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      id_q      <= id_d;
      matched_q <= matched_d;
    end
  end

  assign res_o.valid   = ov_q;
  assign res_o.mat_id  = id_q;
  assign res_o.matched = matched_q;

  // An unmatched pixel always reports id zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.matched |-> res_o.mat_id == '0)
    else $error("unmatched result carries a nonzero id");

  // Input stalls only while a finished result waits at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> res_o.valid)
    else $error("input stalled with empty output register");

  // A result taken while the last root cell holds nothing leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.ready && !cvalid[RootW] |=> !res_o.valid)
    else $error("result repeated after transfer");

endmodule

@@ sim/pixel_hue_material_classifier_tb.sv @@
// Self-checking testbench of the pixel hue material classifier: directed and random pixels.
module pixel_hue_material_classifier_tb;
  import phmc_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] id;
    logic       matched;
  } material_t;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  phmc_pix_if pix ();
  phmc_res_if res ();

  pixel_hue_material_classifier DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix.sink),
    .res_o   (res.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the register file
  logic signed [15:0] thr_q15;
  logic [7:0]         nfloor;
  logic [2:0]         nrefs;
  logic [31:0]        refw [4];

  material_t material_q[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_off = 1'b0;
  int  idle_cycles = 0;

  initial begin
    pix.valid = 1'b0;
    pix.pixel_red = '0;
    pix.pixel_green = '0;
    pix.pixel_blue = '0;
    pix.pixel_alpha = '0;
    res.ready = 1'b0;
  end

  function automatic logic [31:0] int_sqrt(logic [31:0] x);
    logic [31:0] r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint hue_cosine(longint p0, longint p1, longint p2, longint pn,
                                        longint q0, longint q1, longint q2, longint qn);
    longint dot, mag, root;
    logic [127:0] quo;
    if (pn == 0 || qn == 0) return 0;
    dot = p0 * q0 + p1 * q1 + p2 * q2;
    mag = dot < 0 ? -dot : dot;
    quo = ((128'(mag) * 128'(mag)) << 30) / 128'(pn * qn);
    if (quo > 128'h4000_0000) quo = 128'h4000_0000;
    root = int_sqrt(quo[31:0]);
    if (dot < 0) return -root;
    return root > 32767 ? 32767 : root;
  endfunction

  function automatic material_t classify(pixel_t px);
    material_t m;
    longint p0, p1, p2, pn, q0, q1, q2, qn, c, best_c;
    int best, n;
    logic [7:0] qr, qg, qb;
    bit quiet;
    m = '0;
    if (px.alpha == 0) return m;
    p0 = 2 * longint'(px.red) - px.green - px.blue;
    p1 = 2 * longint'(px.green) - px.red - px.blue;
    p2 = 2 * longint'(px.blue) - px.red - px.green;
    pn = p0 * p0 + p1 * p1 + p2 * p2;
    quiet = pn < 9 * longint'(nfloor) * nfloor;
    n = nrefs > 4 ? 4 : nrefs;
    best = -1;
    best_c = -32769;
    for (int k = 0; k < n; k++) begin
      {qr, qg, qb} = refw[k][23:0];
      q0 = 2 * longint'(qr) - qg - qb;
      q1 = 2 * longint'(qg) - qr - qb;
      q2 = 2 * longint'(qb) - qr - qg;
      qn = q0 * q0 + q1 * q1 + q2 * q2;
      c = hue_cosine(p0, p1, p2, pn, q0, q1, q2, qn);
      if (!quiet && c < thr_q15) continue;
      if (c > best_c) begin
        best_c = c;
        best = k;
      end
    end
    if (best >= 0) begin
      m.id = refw[best][31:24];
      m.matched = 1'b1;
    end
    return m;
  endfunction

  task automatic report(string what, material_t got, material_t want);
    $display("mismatch %s: got id %0d matched %0b, want id %0d matched %0b",
             what, got.id, got.matched, want.id, want.matched);
    errors++;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COS_THR:     thr_q15 = value[15:0];
      REG_NOISE_LVL:   nfloor = value[7:0];
      REG_REF_COUNT:   nrefs = value[2:0];
      default:         refw[int'(idx) - int'(REG_REF_WORD0)] = value;
    endcase
  endtask

  // drop the input and wait until every expected result has come
  task automatic drain();
    pix.valid <= 1'b0;
    while (material_q.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  // valid stays high after a transfer; the next item or drain() takes it over
  task automatic send_pixel(pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    {pix.pixel_red, pix.pixel_green, pix.pixel_blue, pix.pixel_alpha} <= px;
    do @(posedge clk_i); while (!pix.ready);
    material_q.insert(material_q.size(), classify(px));
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    px = $urandom;
    if ($urandom_range(9) == 0) px.alpha = 0;
    // near-gray pixels probe the noise floor
    if ($urandom_range(5) == 0) begin
      px.green = px.red + 8'($urandom_range(6)) - 8'd3;
      px.blue = px.red + 8'($urandom_range(6)) - 8'd3;
    end
    return px;
  endfunction

  task automatic random_refs();
    for (int k = 0; k < 4; k++)
      write_reg(reg_idx_e'(int'(REG_REF_WORD0) + k), $urandom);
    write_reg(REG_REF_COUNT, $urandom_range(7));
    write_reg(REG_COS_THR, $urandom);
    write_reg(REG_NOISE_LVL, $urandom_range(40));
  endtask

  task automatic test_directed();
    write_reg(REG_REF_WORD0, {8'd11, 8'd255, 8'd0, 8'd0});
    write_reg(REG_REF_WORD1, {8'd22, 8'd0, 8'd255, 8'd0});
    write_reg(REG_REF_WORD2, {8'd0, 8'd0, 8'd0, 8'd255});
    write_reg(REG_REF_WORD3, {8'd44, 8'd128, 8'd128, 8'd128});
    send_pixel({8'd255, 8'd0, 8'd0, 8'd255});    // no references yet
    drain();
    write_reg(REG_REF_COUNT, 3'd7);               // saturates to four
    send_pixel({8'd255, 8'd0, 8'd0, 8'd0});      // transparent
    send_pixel({8'd255, 8'd0, 8'd0, 8'd255});
    send_pixel({8'd0, 8'd255, 8'd0, 8'd1});
    send_pixel({8'd0, 8'd0, 8'd255, 8'd255});    // zero id wins
    send_pixel({8'd0, 8'd255, 8'd255, 8'd255});  // antiparallel to red
    send_pixel({8'd77, 8'd77, 8'd77, 8'd255});   // gray, under noise floor
    send_pixel({8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel({8'd200, 8'd100, 8'd0, 8'd255});
    drain();
    write_reg(REG_NOISE_LVL, 8'd0);
    write_reg(REG_COS_THR, 32'h8000);
    send_pixel({8'd77, 8'd77, 8'd77, 8'd255});
    send_pixel({8'd0, 8'd255, 8'd255, 8'd255});
    send_pixel({8'd10, 8'd11, 8'd10, 8'd128});
    drain();
    write_reg(REG_COS_THR, 32'h7fff);
    write_reg(REG_NOISE_LVL, 8'd255);
    send_pixel({8'd255, 8'd0, 8'd255, 8'd255});
    send_pixel({8'd255, 8'd0, 8'd0, 8'd255});
    drain();
    write_reg(REG_NOISE_LVL, 8'd0);
    send_pixel({8'd255, 8'd0, 8'd0, 8'd255});
    send_pixel({8'd254, 8'd0, 8'd1, 8'd255});
    drain();
  endtask

  task automatic test_random(int sidle, int ridle, int count);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        drain();
        random_refs();
      end
      send_pixel(random_pixel());
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 1'b1;
    for (int i = 0; i < 60; i++) send_pixel(random_pixel());
    drain();
  endtask

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_off) begin
      if (idle_cycles == 200) hold_off <= 1'b0;
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    res.ready <= !hold_off && $urandom_range(99) >= recv_idle_pct;
  end

  always @(posedge clk_i) begin
    material_t got;
    if (rst_ni && res.valid && res.ready) begin
      got.id = res.mat_id;
      got.matched = res.matched;
      if (material_q.size() == 0) report("unexpected transfer", got, '0);
      else if (got != material_q[0]) begin
        report("result", got, material_q[0]);
        void'(material_q.pop_front());
      end else void'(material_q.pop_front());
    end
  end

  int stuck = 0;
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || psel) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    thr_q15 = 16'sd28378;
    nfloor = 8'd14;
    nrefs = 3'd0;
    for (int k = 0; k < 4; k++) refw[k] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random(14, 84, 200);
    test_random(84, 14, 200);
    test_random(0, 0, 250);
    test_backpressure();
    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
